[rtl/core/rgb565_convert_with_colour_key_mask_core_assert.svh]
// Assertion macros for the RGB565 colour-key converter core.
// Expects signals named clk and rst_n in the including module.
`ifndef RGB565_CONVERT_WITH_COLOUR_KEY_MASK_CORE_ASSERT_SVH
`define RGB565_CONVERT_WITH_COLOUR_KEY_MASK_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// Property must hold in the same cycle.
`define RGBCK_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Property must hold in the cycle after the antecedent.
`define RGBCK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define RGBCK_ASSERT_NOW(lbl, ante, cons, msg)
`define RGBCK_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[rtl/core/rgbck_pkg.sv]
// Shared types, register indexes and the RGB565 packing function
// for the colour-key converter core. No dependencies.
package rgbck_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_MODE   = 2'd2;

  localparam logic [CFG_DATA_W-1:0] IMAGE_WIDTH_RESET = 13'd640;

  // Input kind carried in tuser bit 0.
  localparam logic FUNC_PALETTE_WRITE = 1'b0;
  localparam logic FUNC_CONVERT       = 1'b1;

  // One palette entry as stored in the palette RAM.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pal_entry_t;

  localparam int PAL_ENTRY_W = $bits(pal_entry_t);

  // Red keeps its top 5 bits, green its top 6, blue its top 5.
  function automatic logic [15:0] to_565(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

[rtl/core/rgbck_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module rgbck_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/rgb565_convert_with_colour_key_mask_core.sv]
// Top level of the RGB565 converter with colour-key transparency mask.
// Depends on rgbck_pkg, rgbck_ram and the assertion macro header.
//
// The core takes one beat per clock on its input and gives at most one beat
// per clock on its output, so while the output is not stalled a continuous
// stream runs at one pixel per cycle. An accepted pixel beat passes through
// the registered read of the palette RAM and then into the output register,
// which takes the 565 pixel, the key compare and the mask byte built from it.
// Input beats of kind "palette write" load the palette and produce no output
// beat; a pixel may follow its palette write in the very next cycle and
// sees the new entry. The palette comes up undefined after reset and is not
// cleared, so every palette entry must be written before a pixel uses it;
// indexes at or beyond PALETTE_DEPTH are ignored on write and read as black.
// The pixel marked start_of_image restarts the column count and latches its
// own 565 value as the key colour. In sprite mode every pixel equal to the
// key sets a bit in the mask byte (bit n for column n modulo 8), which is
// delivered with every eighth column and with the last column of each row.
// Configuration registers may only be written while no pixel is in flight.
module rgb565_convert_with_colour_key_mask_core #(
  parameter int PALETTE_DEPTH   = 256,
  parameter int ROW_WIDTH_LIMIT = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Configuration write port.
  input  logic                           cfg_wr_en,
  input  logic [rgbck_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rgbck_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // Input stream.
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [31:0]                    in_tdata,  // colour_index, red_in, green_in, blue_in
  input  logic [1:0]                     in_tuser,  // func, start_of_image
  // Result stream.
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [31:0]                    out_tdata, // pixel_565, is_transparent, mask_byte, zero fill
  output logic                           out_tuser, // mask_byte_valid
  output logic                           out_tlast  // end_of_row
);

  localparam int AW   = $clog2(PALETTE_DEPTH);
  localparam int COLW = $clog2(ROW_WIDTH_LIMIT);
  localparam int CMPW = (COLW + 1 > rgbck_pkg::CFG_DATA_W) ? COLW + 1 : rgbck_pkg::CFG_DATA_W;

  // Input field unpacking.
  logic       in_func;
  logic       in_soi;
  logic [7:0] in_idx;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;
  logic       in_fire;
  logic       in_range;

  assign in_func  = in_tuser[0];
  assign in_soi   = in_tuser[1];
  assign in_idx   = in_tdata[7:0];
  assign in_red   = in_tdata[15:8];
  assign in_green = in_tdata[23:16];
  assign in_blue  = in_tdata[31:24];
  assign in_fire  = in_tvalid && in_tready;
  assign in_range = ({1'b0, in_idx} < 9'(PALETTE_DEPTH));

  // Configuration registers.
  logic                           source_format_r;
  logic [rgbck_pkg::CFG_DATA_W-1:0] image_width_r;
  logic                           sprite_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_format_r <= 1'b0;
      image_width_r   <= rgbck_pkg::IMAGE_WIDTH_RESET;
      sprite_mode_r   <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        rgbck_pkg::CFG_SOURCE_FORMAT: source_format_r <= cfg_wdata[0];
        rgbck_pkg::CFG_IMAGE_WIDTH:   image_width_r   <= cfg_wdata;
        rgbck_pkg::CFG_SPRITE_MODE:   sprite_mode_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Palette RAM. Writes happen on the accept edge of a palette-write beat,
  // reads on the accept edge of a pixel beat; the read data then waits in
  // the RAM output register alongside the first stage.
  rgbck_pkg::pal_entry_t pal_wdata;
  logic [rgbck_pkg::PAL_ENTRY_W-1:0] pal_rdata;

  assign pal_wdata = '{red: in_red, green: in_green, blue: in_blue};

  rgbck_ram #(
    .WIDTH(rgbck_pkg::PAL_ENTRY_W),
    .DEPTH(PALETTE_DEPTH)
  ) u_palette (
    .clk  (clk),
    .we   (in_fire && (in_func == rgbck_pkg::FUNC_PALETTE_WRITE) && in_range),
    .waddr(in_idx[AW-1:0]),
    .wdata(pal_wdata),
    .re   (in_fire && (in_func == rgbck_pkg::FUNC_CONVERT)),
    .raddr(in_idx[AW-1:0]),
    .rdata(pal_rdata)
  );

  // First stage: the pixel beat waits here while its palette read completes.
  logic       s1_valid_r;
  logic       s1_soi_r;
  logic       s1_in_range_r;
  logic [7:0] s1_red_r;
  logic [7:0] s1_green_r;
  logic [7:0] s1_blue_r;
  logic       s1_fire;
  logic       out_can_load;

  // No beat is taken while reset is held.
  assign out_can_load = !out_tvalid || out_tready;
  assign s1_fire      = s1_valid_r && out_can_load;
  assign in_tready    = rst_n && (!s1_valid_r || out_can_load);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_fire && (in_func == rgbck_pkg::FUNC_CONVERT);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && (in_func == rgbck_pkg::FUNC_CONVERT)) begin
      s1_soi_r      <= in_soi;
      s1_in_range_r <= in_range;
      s1_red_r      <= in_red;
      s1_green_r    <= in_green;
      s1_blue_r     <= in_blue;
    end
  end

  // Second stage: conversion, key compare and mask packing.
  rgbck_pkg::pal_entry_t pal_entry;
  logic [7:0]      src_red;
  logic [7:0]      src_green;
  logic [7:0]      src_blue;
  logic [15:0]     pix;
  logic [15:0]     key_r;
  logic [15:0]     key_nxt;
  logic [COLW-1:0] col_r;
  logic [COLW-1:0] col_base;
  logic [COLW-1:0] col_nxt;
  logic [7:0]      acc_r;
  logic [7:0]      acc_base;
  logic [7:0]      acc_or;
  logic [7:0]      acc_nxt;
  logic [CMPW-1:0] width_eff;
  logic            transparent;
  logic            eor;
  logic            group_end;
  logic            mask_valid;

  assign pal_entry = rgbck_pkg::pal_entry_t'(pal_rdata);

  always_comb begin
    if (source_format_r) begin
      // An index outside the palette reads as black.
      src_red   = s1_in_range_r ? pal_entry.red   : 8'd0;
      src_green = s1_in_range_r ? pal_entry.green : 8'd0;
      src_blue  = s1_in_range_r ? pal_entry.blue  : 8'd0;
    end else begin
      src_red   = s1_red_r;
      src_green = s1_green_r;
      src_blue  = s1_blue_r;
    end
  end

  assign pix = rgbck_pkg::to_565(src_red, src_green, src_blue);

  // Start of image restarts the row and latches this pixel as the key.
  assign key_nxt  = s1_soi_r ? pix : key_r;
  assign col_base = s1_soi_r ? '0 : col_r;
  assign acc_base = s1_soi_r ? 8'd0 : acc_r;

  // A width of zero acts as one; anything above the maximum is clamped.
  always_comb begin
    if (image_width_r == '0) begin
      width_eff = CMPW'(1);
    end else if (CMPW'(image_width_r) > CMPW'(ROW_WIDTH_LIMIT)) begin
      width_eff = CMPW'(ROW_WIDTH_LIMIT);
    end else begin
      width_eff = CMPW'(image_width_r);
    end
  end

  assign transparent = sprite_mode_r && (pix == key_nxt);
  assign acc_or      = acc_base | (8'(transparent) << col_base[2:0]);
  assign eor         = (CMPW'(col_base) + CMPW'(1)) >= width_eff;
  assign group_end   = (col_base[2:0] == 3'b111) || eor;
  assign mask_valid  = sprite_mode_r && group_end;
  assign acc_nxt     = group_end ? 8'd0 : acc_or;
  assign col_nxt     = eor ? '0 : col_base + COLW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= 16'd0;
      col_r <= '0;
      acc_r <= 8'd0;
    end else if (s1_fire) begin
      key_r <= key_nxt;
      col_r <= col_nxt;
      acc_r <= acc_nxt;
    end
  end

  // Output register.
  logic        out_valid_r;
  logic [15:0] out_pix_r;
  logic        out_transp_r;
  logic [7:0]  out_mask_r;
  logic        out_mask_valid_r;
  logic        out_eor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_can_load) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_pix_r        <= pix;
      out_transp_r     <= transparent;
      out_mask_r       <= mask_valid ? acc_or : 8'd0;
      out_mask_valid_r <= mask_valid;
      out_eor_r        <= eor;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_mask_r, out_transp_r, out_pix_r};
  assign out_tuser  = out_mask_valid_r;
  assign out_tlast  = out_eor_r;

`include "rgb565_convert_with_colour_key_mask_core_assert.svh"

  // A mask byte that is not marked valid is always zero.
  `RGBCK_ASSERT_NOW(a_mask_zero_when_invalid, out_valid_r && !out_mask_valid_r, out_mask_r == 8'd0, "mask byte nonzero while not valid")
  // The column counter never reaches the maximum row width.
  `RGBCK_ASSERT_NOW(a_col_in_range, 1'b1, CMPW'(col_r) < CMPW'(ROW_WIDTH_LIMIT), "column counter out of range")
  // The accumulator starts empty after every mask group end.
  `RGBCK_ASSERT_NEXT(a_acc_cleared, s1_fire && group_end, acc_r == 8'd0, "mask accumulator not cleared")
  // A pixel held in the first stage is not dropped while the output stalls.
  `RGBCK_ASSERT_NEXT(a_s1_held, s1_valid_r && !out_can_load, s1_valid_r, "stalled pixel lost")

endmodule

[sim/rgb565_key_mask_checker.sv]
// Scoreboard for the RGB565 colour-key converter: follows register writes and both
// streams, predicts every output beat and compares it field by field.
// Depends on rgbck_pkg for register indexes, input kinds and the palette entry type.
module rgb565_key_mask_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [rgbck_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rgbck_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [31:0]                      in_tdata,
  input  logic [1:0]                       in_tuser,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [31:0]                      out_tdata,
  input  logic                             out_tuser,
  input  logic                             out_tlast,
  output int                               fail_count,
  output int                               pending,
  output int                               pixels_seen,
  output int                               mask_bytes_seen,
  output int                               transparent_seen,
  output int                               palette_loads
);

  localparam int WIDTH_CAP   = 4096;
  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    logic [15:0] pixel;
    logic        transparent;
    logic [7:0]  mask;
    logic        mask_valid;
    logic        row_end;
  } pixel_result_t;

  rgbck_pkg::pal_entry_t palette_copy [256];
  logic [15:0]   key_565;
  logic [12:0]   column;
  logic [7:0]    mask_acc;
  logic          fmt_palette;
  logic [12:0]   width_reg;
  logic          sprite_on;
  pixel_result_t expected_pixels [$];

  // Works out one converted pixel and advances the row and mask state.
  task automatic predict_pixel(input logic soi, input logic [7:0] idx,
                               input rgbck_pkg::pal_entry_t direct,
                               output pixel_result_t res);
    rgbck_pkg::pal_entry_t src;
    logic [15:0] pix;
    int          w;
    logic        row_end;
    logic        group_end;
    src = fmt_palette ? palette_copy[idx] : direct;
    pix = {src.red[7:3], src.green[7:2], src.blue[7:3]};
    if (soi) begin
      column   = '0;
      mask_acc = '0;
      key_565  = pix;
    end
    w = (width_reg == 0) ? 1 : ((int'(width_reg) > WIDTH_CAP) ? WIDTH_CAP : int'(width_reg));
    res.pixel       = pix;
    res.transparent = sprite_on && (pix == key_565);
    mask_acc        = mask_acc | (8'(res.transparent) << column[2:0]);
    row_end         = (int'(column) + 1 >= w);
    group_end       = (column[2:0] == 3'd7) || row_end;
    res.mask_valid  = sprite_on && group_end;
    res.mask        = res.mask_valid ? mask_acc : 8'd0;
    res.row_end     = row_end;
    if (group_end) mask_acc = '0;
    column = row_end ? 13'd0 : column + 13'd1;
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t: %s mismatch on pixel %0d: expected %0h, actual %0h",
                 $time, name, pixels_seen, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    pixel_result_t want;
    pixel_result_t got;
    if (!rst_n) begin
      key_565     = '0;
      column      = '0;
      mask_acc    = '0;
      fmt_palette = 1'b0;
      width_reg   = rgbck_pkg::IMAGE_WIDTH_RESET;
      sprite_on   = 1'b0;
      expected_pixels.delete();
      fail_count = 0;
      pixels_seen = 0;
      mask_bytes_seen = 0;
      transparent_seen = 0;
      palette_loads = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          rgbck_pkg::CFG_SOURCE_FORMAT: fmt_palette = cfg_wdata[0];
          rgbck_pkg::CFG_IMAGE_WIDTH:   width_reg   = cfg_wdata;
          rgbck_pkg::CFG_SPRITE_MODE:   sprite_on   = cfg_wdata[0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got.pixel       = out_tdata[15:0];
        got.transparent = out_tdata[16];
        got.mask        = out_tdata[24:17];
        got.mask_valid  = out_tuser;
        got.row_end     = out_tlast;
        if (expected_pixels.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: unexpected output beat: expected none, actual %0h",
                     $time, out_tdata);
        end else begin
          want = expected_pixels.pop_front();
          check_field("pixel_565", want.pixel, got.pixel);
          check_field("is_transparent", 16'(want.transparent), 16'(got.transparent));
          check_field("mask_byte", 16'(want.mask), 16'(got.mask));
          check_field("mask_byte_valid", 16'(want.mask_valid), 16'(got.mask_valid));
          check_field("end_of_row", 16'(want.row_end), 16'(got.row_end));
        end
        pixels_seen++;
        if (got.mask_valid) mask_bytes_seen++;
        if (got.transparent) transparent_seen++;
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser[0] == rgbck_pkg::FUNC_PALETTE_WRITE) begin
          palette_copy[in_tdata[7:0]] =
            rgbck_pkg::pal_entry_t'({in_tdata[15:8], in_tdata[23:16], in_tdata[31:24]});
          palette_loads++;
        end else begin
          predict_pixel(in_tuser[1], in_tdata[7:0],
                        rgbck_pkg::pal_entry_t'({in_tdata[15:8], in_tdata[23:16],
                                                 in_tdata[31:24]}),
                        want);
          expected_pixels.push_back(want);
        end
      end
    end
    pending = expected_pixels.size();
  end

endmodule

[sim/rgb565_convert_with_colour_key_mask_core_tb.sv]
// Testbench top for the RGB565 colour-key converter: clock, reset, register
// settings, input and output traffic, and the final verdict.
// Depends on rgbck_pkg, the converter core and rgb565_key_mask_checker.
module rgb565_convert_with_colour_key_mask_core_tb;

  // The run is bounded well above the slowest legal pass: roughly 1850 beats, each
  // with the longest sender gap and receiver stall, plus the one long hold-off.
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 300;
  // The core has a two-stage pipeline; a palette write leaves no output behind,
  // so a few spare cycles pass before any register write or the verdict.
  localparam int PIPE_SETTLE  = 4;
  localparam int FINAL_SETTLE = 8;

  logic                             clk;
  logic                             rst_n;
  logic                             cfg_wr_en;
  logic [rgbck_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [rgbck_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic                             in_tvalid;
  logic                             in_tready;
  logic [31:0]                      in_tdata;   // colour_index, red_in, green_in, blue_in
  logic [1:0]                       in_tuser;   // func, start_of_image
  logic                             out_tvalid;
  logic                             out_tready;
  logic [31:0]                      out_tdata;  // pixel_565, is_transparent, mask_byte, zero fill
  logic                             out_tuser;  // mask_byte_valid
  logic                             out_tlast;  // end_of_row

  int fail_count;
  int pending;
  int pixels_seen;
  int mask_bytes_seen;
  int transparent_seen;
  int palette_loads;

  int cycle_count;
  int input_stall_cycles;
  int settings_count;

  // Shared between the stimulus and the receiver process; fmt_now is used by the stimulus only.
  bit   no_idle;
  bit   hold_req;
  bit   hold_done;
  logic fmt_now;

  // Palette entries that have been loaded; a palette-mode pixel only ever
  // points at one of these, since unloaded entries read back undefined.
  bit pal_written [256];
  int written_list [$];

  rgb565_convert_with_colour_key_mask_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  rgb565_key_mask_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_tvalid        (in_tvalid),
    .in_tready        (in_tready),
    .in_tdata         (in_tdata),
    .in_tuser         (in_tuser),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_tdata        (out_tdata),
    .out_tuser        (out_tuser),
    .out_tlast        (out_tlast),
    .fail_count       (fail_count),
    .pending          (pending),
    .pixels_seen      (pixels_seen),
    .mask_bytes_seen  (mask_bytes_seen),
    .transparent_seen (transparent_seen),
    .palette_loads    (palette_loads)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog. It also counts the cycles in which the core pushed back on a
  // waiting input beat, which shows that the long hold-off really filled it.
  initial begin
    cycle_count = 0;
    input_stall_cycles = 0;
    while (cycle_count <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
      if (in_tvalid && !in_tready) input_stall_cycles++;
    end
    $display("Timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
    $display("Test completed with failures");
    $finish;
  end

  // Sender gaps: mostly back to back, sometimes a few cycles, now and then long.
  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int receiver_stall();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver. Apart from its random stalls it performs one long hold-off when the
  // stimulus asks for it, while the sender keeps offering beats, so that the
  // pipeline fills and the core has to drop in_tready.
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
        out_tready <= 1'b1;
      end else if (stall_left > 0 && !no_idle) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        stall_left = no_idle ? 0 : receiver_stall();
      end
    end
  end

  // Offers one beat after a random gap and returns at the edge that accepts it.
  // The beat stays on the bus, so a following beat with no gap takes its place
  // without in_tvalid ever dropping.
  task automatic send_beat(input logic [1:0] user, input logic [31:0] data);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= user;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
  endtask

  // Colours are handled as {red, green, blue}; the bus carries blue in the top byte.
  task automatic send_pixel(input logic soi, input logic [7:0] idx, input logic [23:0] rgb);
    send_beat({soi, rgbck_pkg::FUNC_CONVERT}, {rgb[7:0], rgb[15:8], rgb[23:16], idx});
  endtask

  // start_of_image means nothing on a palette write, so it is left random there.
  task automatic send_palette(input logic [7:0] idx, input logic [23:0] rgb);
    send_beat({1'($urandom()), rgbck_pkg::FUNC_PALETTE_WRITE},
              {rgb[7:0], rgb[15:8], rgb[23:16], idx});
    if (!pal_written[idx]) begin
      pal_written[idx] = 1'b1;
      written_list.push_back(idx);
    end
  endtask

  // Half of the picks go to the first few loaded entries so that indexes repeat
  // and pixels often match the key colour.
  function automatic logic [7:0] pick_written_index();
    int top;
    top = written_list.size() - 1;
    if ($urandom_range(0, 1) == 0 && top > 3) top = 3;
    return 8'(written_list[$urandom_range(0, top)]);
  endfunction

  // Lets every expected result arrive, then waits out the pipeline so that a
  // trailing palette write has landed too.
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  // Writes all three registers on consecutive edges with the core idle.
  task automatic apply_settings(input logic fmt, input logic [12:0] width,
                                input logic sprite, input bit quiet);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_index <= rgbck_pkg::CFG_SOURCE_FORMAT;
    cfg_wdata <= {12'd0, fmt};
    @(posedge clk);
    cfg_index <= rgbck_pkg::CFG_IMAGE_WIDTH;
    cfg_wdata <= width;
    @(posedge clk);
    cfg_index <= rgbck_pkg::CFG_SPRITE_MODE;
    cfg_wdata <= {12'd0, sprite};
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    fmt_now = fmt;
    no_idle = quiet;
    settings_count++;
  endtask

  // Random traffic for one register setting. Each phase draws a small pool of
  // colours so that pixels repeat the key colour often enough to build masks;
  // start_of_image comes at the top of most phases and rarely elsewhere, so
  // rows and keys mostly restart at setting changes but sometimes carry over.
  task automatic random_phase(input int n_items);
    logic [23:0] pool [4];
    logic [23:0] rgb;
    logic [7:0]  idx;
    logic        soi;
    int          k;
    for (k = 0; k < 4; k++) pool[k] = 24'($urandom());
    for (k = 0; k < n_items; k++) begin
      if ($urandom_range(0, 99) < 12) begin
        idx = 8'($urandom_range(0, 255));
        rgb = ($urandom_range(0, 2) == 0) ? pool[$urandom_range(0, 3)] : 24'($urandom());
        send_palette(idx, rgb);
      end else begin
        soi = (k == 0 && $urandom_range(0, 9) < 7) || ($urandom_range(0, 99) < 3);
        rgb = ($urandom_range(0, 1) == 0) ? pool[$urandom_range(0, 3)] : 24'($urandom());
        idx = fmt_now ? pick_written_index() : 8'($urandom_range(0, 255));
        send_pixel(soi, idx, rgb);
      end
    end
  endtask

  initial begin : stimulus
    int          ph;
    logic        fmt;
    logic [12:0] width;
    logic        sprite;
    int          n_items;
    bit          quiet;

    rst_n      <= 1'b0;
    cfg_wr_en  <= 1'b0;
    cfg_index  <= rgbck_pkg::CFG_SOURCE_FORMAT;
    cfg_wdata  <= '0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= '0;
    no_idle     = 1'b0;
    hold_req    = 1'b0;
    hold_done   = 1'b0;
    fmt_now     = 1'b0;
    settings_count = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Direct pixels in sprite mode before any start of image: the key is still
    // its reset value of zero, so black and colours that truncate to zero are
    // transparent. The short row makes the mask byte flush at the row end.
    apply_settings(1'b0, 13'd5, 1'b1, 1'b0);
    send_pixel(1'b0, 8'h00, 24'h000000);
    send_pixel(1'b0, 8'h00, 24'h070307);
    send_pixel(1'b0, 8'hFF, 24'hFFFFFF);
    send_pixel(1'b0, 8'h5A, 24'h080408);
    send_pixel(1'b0, 8'hA5, 24'h000000);
    // Palette loads are accepted in direct mode as well.
    send_palette(8'h00, 24'hFFFFFF);
    send_palette(8'hFF, 24'h000000);
    send_palette(8'h01, 24'h804020);
    // A start of image latches magenta as the key; a second one in mid-row
    // restarts the column and the mask.
    send_pixel(1'b1, 8'hFF, 24'hFF00FF);
    send_pixel(1'b0, 8'h00, 24'h00FF00);
    send_pixel(1'b0, 8'h00, 24'hFF00FF);
    send_pixel(1'b1, 8'h00, 24'h000000);

    // Palette pixels on one-pixel rows, every pixel ends a row and a mask group.
    // The load of entry 2 is followed at once by a pixel that reads it.
    apply_settings(1'b1, 13'd1, 1'b1, 1'b1);
    send_pixel(1'b0, 8'h01, 24'h000000);
    send_pixel(1'b0, 8'hFF, 24'hFFFFFF);
    send_palette(8'h02, 24'h123456);
    send_pixel(1'b0, 8'h02, 24'hA5A5A5);
    send_pixel(1'b1, 8'h00, 24'h5A5A5A);
    send_pixel(1'b0, 8'h00, 24'h000000);

    // Width zero behaves as one; outside sprite mode a key from the palette
    // is still latched, but nothing is transparent and no mask byte is valid.
    apply_settings(1'b1, 13'd0, 1'b0, 1'b0);
    send_pixel(1'b0, 8'h00, 24'h000000);
    send_pixel(1'b1, 8'h01, 24'hFFFFFF);
    send_pixel(1'b0, 8'h01, 24'h000000);

    // A row left open at column six is cut short when the width drops to four.
    apply_settings(1'b0, 13'd20, 1'b1, 1'b0);
    send_pixel(1'b1, 8'h00, 24'h102030);
    repeat (5) send_pixel(1'b0, 8'h00, ($urandom_range(0, 1) == 0) ? 24'h102030 : 24'h405060);
    apply_settings(1'b0, 13'd4, 1'b1, 1'b0);
    send_pixel(1'b0, 8'h00, 24'h102030);
    send_pixel(1'b0, 8'h00, 24'h102030);

    // Random phases walk through both formats, both sprite settings, the
    // narrowest and widest rows, a width that saturates, and the reset width.
    for (ph = 0; ph < 11; ph++) begin
      quiet = 1'b0;
      case (ph)
        0:  begin fmt = 1'b0; width = 13'd8;    sprite = 1'b1; n_items = 200; end
        1:  begin fmt = 1'b1; width = 13'd3;    sprite = 1'b1; n_items = 200; end
        2:  begin fmt = 1'b0; width = 13'd4096; sprite = 1'b1; n_items = 150; quiet = 1'b1; end
        3:  begin fmt = 1'b1; width = 13'd8191; sprite = 1'b0; n_items = 100; end
        4:  begin fmt = 1'b0; width = 13'd13;   sprite = 1'b0; n_items = 150; end
        5:  begin fmt = 1'b1; width = 13'd17;   sprite = 1'b1; n_items = 200; quiet = 1'b1; end
        6:  begin fmt = 1'b0; width = 13'd1;    sprite = 1'b1; n_items = 100; end
        7:  begin fmt = 1'b1; width = 13'd9;    sprite = 1'b1; n_items = 200; end
        8:  begin
          fmt = 1'b0; width = 13'($urandom_range(2, 40)); sprite = 1'b1; n_items = 200;
        end
        9:  begin fmt = 1'b1; width = 13'd7;    sprite = 1'b0; n_items = 150; end
        default: begin
          fmt = 1'b0; width = rgbck_pkg::IMAGE_WIDTH_RESET; sprite = 1'b1; n_items = 150;
        end
      endcase
      apply_settings(fmt, width, sprite, quiet);
      // The sender runs flat out in this phase, so the hold-off backs it up.
      if (ph == 5) hold_req = 1'b1;
      random_phase(n_items);
    end

    drain();
    repeat (FINAL_SETTLE) @(posedge clk);
    $display("Summary: %0d pixels checked over %0d register settings, %0d palette loads.",
             pixels_seen, settings_count, palette_loads);
    $display("Summary: %0d mask bytes, %0d transparent pixels, %0d cycles of input backpressure.",
             mask_bytes_seen, transparent_seen, input_stall_cycles);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
